FILE: design/latency_histogram_engine_assert.svh
// ----------------------------------------------------------------------------
// latency histogram engine assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_ENGINE_ASSERT_SVH
`define LATENCY_HISTOGRAM_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LHE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lhe assertion failed");

// next-cycle implication, disabled while reset is low
`define LHE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lhe assertion failed");

`endif

FILE: design/lhe_pkg.sv
// ----------------------------------------------------------------------------
// lhe_pkg
// types, codes and constants of the latency histogram engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhe_pkg;

  // stream payload widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  // histogram layout
  localparam int          WORDS_PER_HIST = 11;
  localparam logic [3:0]  NUM_BUCKETS    = 4'd9;
  localparam logic [3:0]  LAST_BUCKET    = 4'd8;
  localparam logic [3:0]  COUNT_WORD     = 4'd9;
  localparam logic [3:0]  SUM_WORD       = 4'd10;
  localparam logic [3:0]  OVERFLOW_WORD  = 4'd11;

  // bucket upper bounds in us
  localparam logic [9:0] BUCKET_LIMITS [8] = '{
    10'd5, 10'd10, 10'd25, 10'd50, 10'd100, 10'd250, 10'd500, 10'd1000
  };

  // operation codes
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // scope codes
  localparam logic [1:0] SCOPE_PROCESS = 2'd0;
  localparam logic [1:0] SCOPE_SESSION = 2'd1;
  localparam logic [1:0] SCOPE_MISSION = 2'd2;

  // sequencer step counts
  localparam logic [2:0] STEPS_ONE = 3'd3;
  localparam logic [2:0] STEPS_TWO = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_READ,
    ST_DONE
  } state_t;

  // first bucket whose bound covers the duration, else the overflow bucket
  function automatic logic [3:0] pick_bucket(input logic [63:0] d);
    logic [3:0] b;
    b = LAST_BUCKET;
    for (int i = 7; i >= 0; i--) begin
      if (d <= 64'(BUCKET_LIMITS[i])) begin
        b = 4'(i);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/latency_histogram_engine.sv
// ----------------------------------------------------------------------------
// latency_histogram_engine
// per-process, per-session and per-mission latency histograms with
// saturating 64-bit counters, one shared adder and one counter ram
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_tvalid/in_tready  tuser: operation; tdata: request
//   out_     output     out_tvalid/out_tready tuser: status; tdata: result
//   cfg_     input      cfg_we               cfg_wdata: enabled flag
//
// - an accepted item passes ST_SETUP, then ST_RUN for an observe or ST_READ for a
//   counter read, then ST_DONE; a dropped item or an overflow word read goes from
//   ST_SETUP to ST_DONE; in ST_RUN the single ram port pair reads one word and
//   writes one back through the saturating adder per cycle
// - the block takes one item at a time; in_tready is high only while idle
// - after reset a clearing pass zeroes the counter ram, one word a cycle,
//   (2 + NUM_SESSIONS) * NUM_HISTOGRAMS * 11 words (264 at the defaults);
//   configuration writes are taken during it
// - the result sits in an output register, so the next item is accepted
//   while out_tready stalls the previous result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module latency_histogram_engine #(
  parameter int NUM_HISTOGRAMS = 4,
  parameter int NUM_SESSIONS   = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request item
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,   // [0] operation
  input  logic [lhe_pkg::IN_DATA_W-1:0]    in_tdata,   // [1:0] scope, [5:2] slot,
                                                       // [9:6] histogram_id,
                                                       // [73:10] duration,
                                                       // [77:74] word_select,
                                                       // [79:78] zero
  // result item
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [1:0]                       out_tuser,  // [0] accepted, [1] saturated
  output logic [lhe_pkg::OUT_DATA_W-1:0]   out_tdata,  // [3:0] bucket_index,
                                                       // [67:4] read_value,
                                                       // [71:68] zero
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_wdata   // enabled
);

  import lhe_pkg::*;

  // memory map: process histograms, then mission, then session slots
  localparam int NUM_HIST_TOTAL = (2 + NUM_SESSIONS) * NUM_HISTOGRAMS;
  localparam int MEM_DEPTH      = NUM_HIST_TOTAL * WORDS_PER_HIST;
  localparam int AW             = $clog2(MEM_DEPTH);
  localparam int HW             = $clog2(NUM_HIST_TOTAL);
  localparam int MISSION_BASE   = NUM_HISTOGRAMS;
  localparam int SESSION_BASE   = 2 * NUM_HISTOGRAMS;

  state_t state_r, state_nxt;

  logic          enabled_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // captured request
  logic          op_r, op_nxt;
  logic [1:0]    scope_r, scope_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [3:0]    hid_r, hid_nxt;
  logic [63:0]   dur_r, dur_nxt;
  logic [3:0]    sel_r, sel_nxt;

  // sequencer
  logic [AW-1:0] p_base_r, p_base_nxt;
  logic [AW-1:0] s_base_r, s_base_nxt;
  logic          two_hist_r, two_hist_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          sat_any_r, sat_any_nxt;
  logic          res_accept_r, res_accept_nxt;
  logic          res_from_mem_r, res_from_mem_nxt;
  logic [63:0]   res_value_r, res_value_nxt;
  logic [63:0]   ovf_total_r, ovf_total_nxt;

  // output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [1:0]            out_tuser_r, out_tuser_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // request decode
  logic          in_accept;
  logic [3:0]    bucket_w;
  logic          hid_ok, slot_ok, loc_ok, obs_ok, rd_ok, rd_ovf;
  logic [HW-1:0] p_hist, s_hist;
  logic [2:0]    step_last;
  logic          clr_done, out_load;

  // ram and shared adder
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;
  logic [2:0]    wr_k;
  logic [3:0]    wr_word, rd_word;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   add_amt, sum_w;
  logic          sat_w;

  // word of a histogram touched at a sequencer step: bucket, count, sum
  function automatic logic [3:0] step_word(input logic [2:0] k, input logic [3:0] b);
    logic [3:0] w;
    case (k)
      3'd0, 3'd3: w = b;
      3'd1, 3'd4: w = COUNT_WORD;
      default:    w = SUM_WORD;
    endcase
    return w;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign bucket_w  = pick_bucket(dur_r);

  // addressability of the captured request
  assign hid_ok  = 32'(hid_r) < NUM_HISTOGRAMS;
  assign slot_ok = 32'(slot_r) < NUM_SESSIONS;
  assign loc_ok  = hid_ok && ((scope_r == SCOPE_PROCESS) || (scope_r == SCOPE_MISSION)
                              || ((scope_r == SCOPE_SESSION) && slot_ok));
  assign obs_ok  = enabled_r && loc_ok;
  assign rd_ovf  = (sel_r == OVERFLOW_WORD);
  assign rd_ok   = (sel_r <= SUM_WORD) && loc_ok;

  assign p_hist = HW'(hid_r);
  always_comb begin
    case (scope_r)
      SCOPE_SESSION: s_hist = HW'(SESSION_BASE) + HW'(slot_r) * HW'(NUM_HISTOGRAMS)
                              + HW'(hid_r);
      SCOPE_MISSION: s_hist = HW'(MISSION_BASE) + HW'(hid_r);
      default:       s_hist = p_hist;
    endcase
  end

  assign step_last = two_hist_r ? STEPS_TWO : STEPS_ONE;
  assign clr_done  = (clr_addr_r == AW'(MEM_DEPTH - 1));
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // read for step k, write back for step k-1 in the same cycle
  assign wr_k    = step_r - 3'd1;
  assign wr_word = step_word(wr_k, bucket_w);
  assign rd_word = step_word(step_r, bucket_w);
  assign wr_addr = ((wr_k >= STEPS_ONE) ? s_base_r : p_base_r) + AW'(wr_word);
  assign rd_addr = ((step_r >= STEPS_ONE) ? s_base_r : p_base_r) + AW'(rd_word);
  assign add_amt = (wr_word == SUM_WORD) ? dur_r : 64'd1;

  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_RUN) && (step_r != 3'd0));
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr;
  assign ram_wdata = (state_r == ST_CLEAR) ? 64'd0 : sum_w;
  assign ram_re    = (state_r == ST_READ) || ((state_r == ST_RUN) && (step_r < step_last));
  assign ram_raddr = (state_r == ST_READ) ? (s_base_r + AW'(sel_r)) : rd_addr;

  lhe_ram #(
    .WIDTH (64),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lhe_sat_add u_sat_add (
    .a   (ram_rdata),
    .b   (add_amt),
    .sum (sum_w),
    .sat (sat_w)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (op_r == OP_OBSERVE) begin
          state_nxt = obs_ok ? ST_RUN : ST_DONE;
        end else if (!rd_ovf && rd_ok) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RUN: begin
        if (step_r == step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_addr_nxt     = clr_addr_r;
    op_nxt           = op_r;
    scope_nxt        = scope_r;
    slot_nxt         = slot_r;
    hid_nxt          = hid_r;
    dur_nxt          = dur_r;
    sel_nxt          = sel_r;
    p_base_nxt       = p_base_r;
    s_base_nxt       = s_base_r;
    two_hist_nxt     = two_hist_r;
    step_nxt         = step_r;
    sat_any_nxt      = sat_any_r;
    res_accept_nxt   = res_accept_r;
    res_from_mem_nxt = res_from_mem_r;
    res_value_nxt    = res_value_r;
    ovf_total_nxt    = ovf_total_r;
    out_tvalid_nxt   = out_tvalid_r;
    out_tuser_nxt    = out_tuser_r;
    out_tdata_nxt    = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: clr_addr_nxt = clr_addr_r + AW'(1);
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_tuser;
          scope_nxt = in_tdata[1:0];
          slot_nxt  = in_tdata[5:2];
          hid_nxt   = in_tdata[9:6];
          dur_nxt   = in_tdata[73:10];
          sel_nxt   = in_tdata[77:74];
        end
      end
      ST_SETUP: begin
        p_base_nxt       = AW'(p_hist) * AW'(WORDS_PER_HIST);
        s_base_nxt       = AW'(s_hist) * AW'(WORDS_PER_HIST);
        two_hist_nxt     = (scope_r != SCOPE_PROCESS);
        step_nxt         = 3'd0;
        sat_any_nxt      = 1'b0;
        res_from_mem_nxt = 1'b0;
        res_value_nxt    = 64'd0;
        if (op_r == OP_OBSERVE) begin
          res_accept_nxt = obs_ok;
        end else if (rd_ovf) begin
          res_accept_nxt = 1'b1;
          res_value_nxt  = ovf_total_r;
        end else begin
          res_accept_nxt   = rd_ok;
          res_from_mem_nxt = rd_ok;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 3'd1;
        // every saturating write-back bumps the shared overflow counter, which itself saturates
        if ((step_r != 3'd0) && sat_w) begin
          sat_any_nxt = 1'b1;
          if (ovf_total_r != '1) begin
            ovf_total_nxt = ovf_total_r + 64'd1;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = {sat_any_r, res_accept_r};
          out_tdata_nxt  = {4'd0, (res_from_mem_r ? ram_rdata : res_value_r),
                            ((op_r == OP_OBSERVE) ? bucket_w : 4'd0)};
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      enabled_r    <= 1'b0;
      ovf_total_r  <= 64'd0;
      out_tvalid_r <= 1'b0;
      step_r       <= 3'd0;
      two_hist_r   <= 1'b0;
      sat_any_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      ovf_total_r  <= ovf_total_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      step_r       <= step_nxt;
      two_hist_r   <= two_hist_nxt;
      sat_any_r    <= sat_any_nxt;
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    scope_r        <= scope_nxt;
    slot_r         <= slot_nxt;
    hid_r          <= hid_nxt;
    dur_r          <= dur_nxt;
    sel_r          <= sel_nxt;
    p_base_r       <= p_base_nxt;
    s_base_r       <= s_base_nxt;
    res_accept_r   <= res_accept_nxt;
    res_from_mem_r <= res_from_mem_nxt;
    res_value_r    <= res_value_nxt;
    out_tuser_r    <= out_tuser_nxt;
    out_tdata_r    <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: design/lhe_ram.sv
// ----------------------------------------------------------------------------
// lhe_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/lhe_sat_add.sv
// ----------------------------------------------------------------------------
// lhe_sat_add
// shared 64-bit saturating adder used by every counter update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhe_sat_add (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] sum,
  output logic        sat
);

  logic [64:0] full;

  assign full = {1'b0, a} + {1'b0, b};
  assign sat  = full[64];
  assign sum  = full[64] ? '1 : full[63:0];

endmodule

`default_nettype wire

FILE: design/lhe_assert_chk.sv
// ----------------------------------------------------------------------------
// lhe_assert_chk
// port-level checks of the latency histogram engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "latency_histogram_engine_assert.svh"

module lhe_assert_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [1:0]                     out_tuser,
  input  logic [lhe_pkg::OUT_DATA_W-1:0] out_tdata
);

  import lhe_pkg::*;

  // a stalled result holds
  `LHE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one item at a time: busy right after an accept
  `LHE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // saturation only reported on a performed observe
  `LHE_ASSERT_IMP(a_sat_needs_accept, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0])

  // dropped items carry no counter word, bucket stays in range
  `LHE_ASSERT_IMP(a_drop_zero_value, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[67:4] == 64'd0)
  `LHE_ASSERT_IMP(a_bucket_range, clk, rst_n, out_tvalid, out_tdata[3:0] <= LAST_BUCKET)

endmodule

bind latency_histogram_engine lhe_assert_chk u_lhe_assert_chk (.*);

`default_nettype wire

FILE: verif/latency_histogram_engine_test.sv
// ----------------------------------------------------------------------------
// latency_histogram_engine_test
// self-checking bench for the latency histogram engine: a stream driver and a
// result monitor around the block, with an in-bench predictor of the bucket,
// count, sum and overflow counters checked item by item on every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latency_histogram_engine_test;
  import lhe_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int NUM_HIST       = 4;
  localparam int NUM_SESS       = 4;
  localparam int HIST_TOTAL     = (2 + NUM_SESS) * NUM_HIST;
  localparam int SETTLE_CYCLES  = 16;    // covers the longest observe plus output stage
  localparam int LONG_HOLD      = 400;   // receiver hold-off that backs up the input
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles allowed, covers clear pass and hold

  // a scope code the block has no histogram for
  localparam logic [1:0] SCOPE_NONE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [1:0]  scope;
    logic [3:0]  slot;
    logic [3:0]  hid;
    logic [63:0] dur;
    logic [3:0]  sel;
  } request_t;

  typedef struct packed {
    logic        accepted;
    logic        saturated;
    logic [3:0]  bucket;
    logic [63:0] value;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic                  in_tuser = 1'b0;        // [0] operation
  logic [IN_DATA_W-1:0]  in_tdata = '0;          // [1:0] scope, [5:2] slot, [9:6] histogram_id,
                                                 // [73:10] duration, [77:74] word_select
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [1:0]            out_tuser;              // [0] accepted, [1] saturated
  logic [OUT_DATA_W-1:0] out_tdata;              // [3:0] bucket_index, [67:4] read_value
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;

  // predictor state: process histograms first, then mission, then session slots
  logic [63:0] counter_words [HIST_TOTAL * WORDS_PER_HIST];
  logic [63:0] overflow_tally;
  logic        histograms_enabled;
  logic        any_saturation;

  request_t request_backlog [$];
  result_t  awaited_results [$];
  request_t offered;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  int       pattern_left = 0;
  int       stall_mode = 0;
  logic     long_hold_req = 1'b0;
  int       quiet_cycles = 0;
  int       mismatch_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  latency_histogram_engine #(
    .NUM_HISTOGRAMS(NUM_HIST),
    .NUM_SESSIONS  (NUM_SESS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic logic [63:0] bucket_bound(int i);
    case (i)
      0: return 64'd5;
      1: return 64'd10;
      2: return 64'd25;
      3: return 64'd50;
      4: return 64'd100;
      5: return 64'd250;
      6: return 64'd500;
      default: return 64'd1000;
    endcase
  endfunction

  // first bucket whose upper bound covers the duration
  function automatic logic [3:0] bucket_for(logic [63:0] d);
    for (int i = 0; i < 8; i++) begin
      if (d <= bucket_bound(i)) return 4'(i);
    end
    return LAST_BUCKET;
  endfunction

  // clamps at all ones, each clamp bumps the shared overflow tally (itself clamped)
  function automatic logic [63:0] clamped_sum(logic [63:0] word, logic [63:0] amount);
    logic [64:0] total;
    total = {1'b0, word} + {1'b0, amount};
    if (total[64]) begin
      any_saturation = 1'b1;
      if (overflow_tally != '1) overflow_tally = overflow_tally + 64'd1;
      return '1;
    end
    return total[63:0];
  endfunction

  function automatic void bump_histogram(int h, logic [3:0] b, logic [63:0] d);
    int base;
    base = h * WORDS_PER_HIST;
    counter_words[base + b] = clamped_sum(counter_words[base + b], 64'd1);
    counter_words[base + COUNT_WORD] = clamped_sum(counter_words[base + COUNT_WORD], 64'd1);
    counter_words[base + SUM_WORD] = clamped_sum(counter_words[base + SUM_WORD], d);
  endfunction

  // histogram number addressed by an item, -1 when it has none
  function automatic int locate_histogram(logic [1:0] scope, logic [3:0] slot,
                                          logic [3:0] hid);
    if (hid >= NUM_HIST) return -1;
    case (scope)
      SCOPE_PROCESS: return int'(hid);
      SCOPE_MISSION: return NUM_HIST + int'(hid);
      SCOPE_SESSION: begin
        if (slot >= NUM_SESS) return -1;
        return 2 * NUM_HIST + int'(slot) * NUM_HIST + int'(hid);
      end
      default: return -1;
    endcase
  endfunction

  function automatic result_t histogram_outcome(request_t r);
    result_t res;
    int      h;
    res = '0;
    h = locate_histogram(r.scope, r.slot, r.hid);
    if (r.op == OP_OBSERVE) begin
      // bucket is reported even when the observe is dropped
      res.bucket = bucket_for(r.dur);
      if (histograms_enabled && h >= 0) begin
        any_saturation = 1'b0;
        bump_histogram(int'(r.hid), res.bucket, r.dur);
        if (r.scope != SCOPE_PROCESS) bump_histogram(h, res.bucket, r.dur);
        res.accepted  = 1'b1;
        res.saturated = any_saturation;
      end
    end else if (r.sel == OVERFLOW_WORD) begin
      // overflow word ignores scope, slot and id
      res.accepted = 1'b1;
      res.value    = overflow_tally;
    end else if (r.sel <= SUM_WORD && h >= 0) begin
      res.accepted = 1'b1;
      res.value    = counter_words[h * WORDS_PER_HIST + r.sel];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [63:0] random_duration();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return bucket_bound($urandom_range(0, 7)) + $urandom_range(0, 2) - 1;
      5, 6:          return 64'($urandom_range(0, 1200));
      7:             return {$urandom, $urandom};
      8:             return '1 - 64'($urandom_range(0, 3));   // drives the sum word to clamp
      default:       return 64'($urandom_range(0, 20));
    endcase
  endfunction

  // mostly well-formed items on the few valid histograms, some bad codes mixed in
  function automatic request_t random_request();
    request_t r;
    r.op    = ($urandom_range(0, 9) < 6) ? OP_OBSERVE : OP_READ;
    r.scope = ($urandom_range(0, 19) == 0) ? SCOPE_NONE : 2'($urandom_range(0, 2));
    r.slot  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(NUM_SESS, 15))
                                          : 4'($urandom_range(0, NUM_SESS - 1));
    r.hid   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(NUM_HIST, 15))
                                          : 4'($urandom_range(0, NUM_HIST - 1));
    r.dur   = random_duration();
    r.sel   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
    return r;
  endfunction

  task automatic queue_request(input logic op, input logic [1:0] scope, input logic [3:0] slot,
                               input logic [3:0] hid, input logic [63:0] dur,
                               input logic [3:0] sel);
    request_backlog.push_back('{op: op, scope: scope, slot: slot, hid: hid, dur: dur, sel: sel});
  endtask

  task automatic queue_random(input int n);
    repeat (n) request_backlog.push_back(random_request());
  endtask

  // sender pause: nothing offered, nothing in flight, then let the block settle
  task automatic wait_drained();
    while (request_backlog.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_enabled(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    histograms_enabled = v;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of random length with random gaps, valid held until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(histogram_outcome(offered));
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      // the offered item may only change once it has been taken
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || request_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          offered = request_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= offered.op;
          in_tdata  <= {2'b00, offered.sel, offered.dur, offered.hid, offered.slot,
                        offered.scope};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern switching between always ready, half and sparse,
  // plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left    = 0;
      pattern_left = 0;
    end else begin
      if (long_hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 200);
          stall_mode   = $urandom_range(0, 2);
        end
        pattern_left--;
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each result against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with no expectation waiting");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("accepted", want.accepted, out_tuser[0]);
        check_field("saturated", want.saturated, out_tuser[1]);
        check_field("bucket_index", want.bucket, out_tdata[3:0]);
        check_field("read_value", want.value, out_tdata[67:4]);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("latency_histogram_engine_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    foreach (counter_words[i]) counter_words[i] = '0;
    overflow_tally     = '0;
    histograms_enabled = 1'b0;
    any_saturation     = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // disabled: observes dropped with bucket reported, reads still served
    set_enabled(1'b0);
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd0, 64'd25, 4'd0);
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd0, 64'd0, COUNT_WORD);
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd0, 64'd0, OVERFLOW_WORD);
    wait_drained();

    set_enabled(1'b1);
    // bucket edges in process scope
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd0, 64'd0, 4'd0);
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd0, 64'd5, 4'd0);
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd1, 64'd6, 4'd0);
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd1, 64'd1000, 4'd0);
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd2, 64'd1001, 4'd0);
    // session updates its slot and the process histogram
    queue_request(OP_OBSERVE, SCOPE_SESSION, 4'd3, 4'd3, 64'd10, 4'd0);
    // bad slot, bad id, bad scope: dropped entirely
    queue_request(OP_OBSERVE, SCOPE_SESSION, 4'd4, 4'd0, 64'd7, 4'd0);
    queue_request(OP_OBSERVE, SCOPE_PROCESS, 4'd0, 4'd15, 64'd7, 4'd0);
    queue_request(OP_OBSERVE, SCOPE_NONE, 4'd0, 4'd0, 64'd7, 4'd0);
    // largest durations twice: sum words clamp, slot ignored outside session
    queue_request(OP_OBSERVE, SCOPE_MISSION, 4'd15, 4'd0, '1, 4'hf);
    queue_request(OP_OBSERVE, SCOPE_MISSION, 4'd0, 4'd0, '1, 4'd0);
    // overflow word whatever the addressing
    queue_request(OP_READ, SCOPE_NONE, 4'd15, 4'd15, '1, OVERFLOW_WORD);
    queue_request(OP_READ, SCOPE_MISSION, 4'd0, 4'd0, 64'd0, SUM_WORD);
    queue_request(OP_READ, SCOPE_MISSION, 4'd0, 4'd0, 64'd0, COUNT_WORD);
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd0, 64'd0, 4'd0);
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd2, 64'd0, LAST_BUCKET);
    queue_request(OP_READ, SCOPE_SESSION, 4'd3, 4'd3, 64'd0, 4'd1);
    // word selects past the overflow word, bad slot, bad scope, bad id
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd0, 64'd0, 4'd12);
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd0, 64'd0, 4'd15);
    queue_request(OP_READ, SCOPE_SESSION, 4'd4, 4'd0, 64'd0, 4'd0);
    queue_request(OP_READ, SCOPE_NONE, 4'd0, 4'd0, 64'd0, 4'd0);
    queue_request(OP_READ, SCOPE_PROCESS, 4'd0, 4'd4, 64'd0, COUNT_WORD);
    wait_drained();

    // random, enabled, with the long receiver hold-off while items keep coming
    queue_random(350);
    @(posedge clk);
    long_hold_req <= 1'b1;
    @(posedge clk);
    long_hold_req <= 1'b0;
    wait_drained();

    // random, disabled: counters frozen, reads still check the stores
    set_enabled(1'b0);
    queue_random(150);
    wait_drained();

    // random, enabled again, with a full pause in the middle
    set_enabled(1'b1);
    queue_random(250);
    wait_drained();
    queue_random(250);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("latency_histogram_engine_test OK");
    end else begin
      $display("latency_histogram_engine_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lhe_pkg.sv
design/lhe_ram.sv
design/lhe_sat_add.sv
design/latency_histogram_engine.sv
design/lhe_assert_chk.sv
verif/latency_histogram_engine_test.sv
